// File: rtl/jsu_pkg.sv
// JSON string unescape: shared types, character codes and the UTF-8 encoder.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam int unsigned BURST_MAX = 7;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_TEXT,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNCLOSED  = 3'd1,
		ERR_OPEN_ESC  = 3'd2,
		ERR_SHORT_HEX = 3'd3,
		ERR_BAD_HEX   = 3'd4,
		ERR_BAD_ESC   = 3'd5,
		ERR_CTRL      = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		P2_NONE,
		P2_RAW,
		P2_CODE
	} p2_t;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_DONE,
		MK_ERR
	} mk_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_CTRL_END = 8'h20;

	localparam logic [15:0] HI_LO = 16'hD800;
	localparam logic [15:0] HI_HI = 16'hDBFF;
	localparam logic [15:0] LO_LO = 16'hDC00;
	localparam logic [15:0] LO_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} item_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       done_res;
		logic [2:0] error_code;
		logic       last;
	} item_out_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_count;
		logic [15:0] hex_value;
		logic        hex_bad;
		logic [15:0] pending_high;
		logic        high_waiting;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode: MODE_START, hex_count: 2'd0, hex_value: 16'd0, hex_bad: 1'b0,
		pending_high: 16'd0, high_waiting: 1'b0
	};

	typedef struct packed {
		logic        flush;
		p2_t         p2;
		logic [7:0]  raw;
		logic [20:0] code;
		mk_t         mk;
		err_t        err;
		logic        ended;
	} dec_t;

	typedef struct packed {
		item_out_t [BURST_MAX-1:0] ent;
		logic [2:0]                cnt;
		logic                      ends;
	} burst_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      cnt;
	} enc_t;

	function automatic enc_t utf8_enc(input logic [20:0] code);
		enc_t e;
		e = '0;
		if (code < 21'h80) begin
			e.b[0] = code[7:0];
			e.cnt  = 3'd1;
		end else if (code < 21'h800) begin
			e.b[0] = 8'hC0 | {3'b000, code[10:6]};
			e.b[1] = 8'h80 | {2'b00, code[5:0]};
			e.cnt  = 3'd2;
		end else if (code < SUPP_BASE) begin
			e.b[0] = 8'hE0 | {4'b0000, code[15:12]};
			e.b[1] = 8'h80 | {2'b00, code[11:6]};
			e.b[2] = 8'h80 | {2'b00, code[5:0]};
			e.cnt  = 3'd3;
		end else begin
			e.b[0] = 8'hF0 | {5'b00000, code[20:18]};
			e.b[1] = 8'h80 | {2'b00, code[17:12]};
			e.b[2] = 8'h80 | {2'b00, code[11:6]};
			e.b[3] = 8'h80 | {2'b00, code[5:0]};
			e.cnt  = 3'd4;
		end
		return e;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_decode.sv
// Per-byte decoder: next escape state and the burst of result items for one byte.
// Purely combinational; uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
	input  wire jsu_pkg::state_t   st,
	input  wire jsu_pkg::item_in_t item,
	output jsu_pkg::state_t        nx,
	output jsu_pkg::burst_t        burst
);

	jsu_pkg::dec_t dec;

	// next state and decision
	always_comb begin
		logic       hw_old;
		logic       hw_new;
		logic [4:0] hd;
		logic       bad;
		logic [15:0] val;
		logic [7:0] b;

		b      = item.in_byte;
		nx     = st;
		dec    = '0;
		dec.p2 = jsu_pkg::P2_NONE;
		dec.mk = jsu_pkg::MK_NONE;
		dec.err = jsu_pkg::ERR_NONE;
		hw_old = st.high_waiting;
		hw_new = 1'b0;
		hd     = jsu_pkg::hex_digit(b);
		bad    = st.hex_bad | ~hd[4];
		val    = {st.hex_value[11:0], hd[3:0]};

		unique case (st.mode)
			jsu_pkg::MODE_START: begin
				nx.mode = jsu_pkg::MODE_TEXT;
			end
			jsu_pkg::MODE_TEXT: begin
				if (hw_old && b == jsu_pkg::CH_BSL) begin
					nx.mode = jsu_pkg::MODE_ESC;
				end else begin
					if (hw_old) begin
						dec.flush = 1'b1;
						hw_old = 1'b0;
					end
					if (b == jsu_pkg::CH_QUOTE) begin
						dec.mk    = jsu_pkg::MK_DONE;
						dec.ended = 1'b1;
					end else if (b == jsu_pkg::CH_BSL) begin
						nx.mode = jsu_pkg::MODE_ESC;
					end else if (b < jsu_pkg::CH_CTRL_END) begin
						dec.mk    = jsu_pkg::MK_ERR;
						dec.err   = jsu_pkg::ERR_CTRL;
						dec.ended = 1'b1;
					end else begin
						dec.p2  = jsu_pkg::P2_RAW;
						dec.raw = b;
					end
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (hw_old && b == jsu_pkg::CH_U) begin
					nx.mode      = jsu_pkg::MODE_HEX;
					nx.hex_count = 2'd0;
					nx.hex_value = 16'd0;
					nx.hex_bad   = 1'b0;
				end else begin
					if (hw_old) begin
						dec.flush = 1'b1;
						hw_old = 1'b0;
					end
					nx.mode = jsu_pkg::MODE_TEXT;
					dec.p2  = jsu_pkg::P2_RAW;
					case (b) inside
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: dec.raw = b;
						jsu_pkg::CH_N: dec.raw = 8'h0A;
						jsu_pkg::CH_R: dec.raw = 8'h0D;
						jsu_pkg::CH_T: dec.raw = 8'h09;
						jsu_pkg::CH_B: dec.raw = 8'h08;
						jsu_pkg::CH_F: dec.raw = 8'h0C;
						jsu_pkg::CH_U: begin
							dec.p2       = jsu_pkg::P2_NONE;
							nx.mode      = jsu_pkg::MODE_HEX;
							nx.hex_count = 2'd0;
							nx.hex_value = 16'd0;
							nx.hex_bad   = 1'b0;
						end
						default: begin
							dec.p2    = jsu_pkg::P2_NONE;
							dec.mk    = jsu_pkg::MK_ERR;
							dec.err   = jsu_pkg::ERR_BAD_ESC;
							dec.ended = 1'b1;
						end
					endcase
				end
			end
			jsu_pkg::MODE_HEX: begin
				nx.hex_value = val;
				nx.hex_bad   = bad;
				nx.hex_count = st.hex_count + 2'd1;
				if (st.hex_count == 2'd3) begin
					if (bad) begin
						if (hw_old) begin
							dec.flush = 1'b1;
							hw_old = 1'b0;
						end
						dec.mk    = jsu_pkg::MK_ERR;
						dec.err   = jsu_pkg::ERR_BAD_HEX;
						dec.ended = 1'b1;
					end else if (hw_old && val >= jsu_pkg::LO_LO && val <= jsu_pkg::LO_HI) begin
						hw_old   = 1'b0;
						nx.mode  = jsu_pkg::MODE_TEXT;
						dec.p2   = jsu_pkg::P2_CODE;
						dec.code = jsu_pkg::SUPP_BASE
							+ {1'b0, st.pending_high[9:0], val[9:0]};
					end else begin
						if (hw_old) begin
							dec.flush = 1'b1;
							hw_old = 1'b0;
						end
						nx.mode = jsu_pkg::MODE_TEXT;
						if (val >= jsu_pkg::HI_LO && val <= jsu_pkg::HI_HI) begin
							hw_new          = 1'b1;
							nx.pending_high = val;
						end else begin
							dec.p2   = jsu_pkg::P2_CODE;
							dec.code = {5'd0, val};
						end
					end
				end
			end
			default: nx.mode = jsu_pkg::MODE_START;
		endcase

		if (!dec.ended && item.last_in) begin
			dec.mk = jsu_pkg::MK_ERR;
			if (nx.mode == jsu_pkg::MODE_ESC) begin
				dec.err = jsu_pkg::ERR_OPEN_ESC;
			end else if (nx.mode == jsu_pkg::MODE_HEX) begin
				dec.err = jsu_pkg::ERR_SHORT_HEX;
			end else begin
				dec.err = jsu_pkg::ERR_UNCLOSED;
			end
			if (hw_old) begin
				dec.flush = 1'b1;
				hw_old = 1'b0;
			end
			if (hw_new) begin
				dec.p2   = jsu_pkg::P2_CODE;
				dec.code = {5'd0, val};
				hw_new   = 1'b0;
			end
			dec.ended = 1'b1;
		end

		nx.high_waiting = hw_old | hw_new;
		if (dec.ended) begin
			nx = jsu_pkg::STATE_RESET;
		end
	end

	// result items of this byte, in order: flushed high surrogate, raw byte or encoded code, marker
	always_comb begin
		jsu_pkg::enc_t enc;
		logic [2:0]    n;

		burst = '0;
		n     = 3'd0;
		enc   = jsu_pkg::utf8_enc(dec.code);

		if (dec.flush) begin
			burst.ent[0].out_byte = 8'hE0 | {4'd0, st.pending_high[15:12]};
			burst.ent[1].out_byte = 8'h80 | {2'd0, st.pending_high[11:6]};
			burst.ent[2].out_byte = 8'h80 | {2'd0, st.pending_high[5:0]};
			burst.ent[0].has_byte = 1'b1;
			burst.ent[1].has_byte = 1'b1;
			burst.ent[2].has_byte = 1'b1;
			n = 3'd3;
		end

		if (dec.p2 == jsu_pkg::P2_RAW) begin
			burst.ent[n].out_byte = dec.raw;
			burst.ent[n].has_byte = 1'b1;
			n = n + 3'd1;
		end else if (dec.p2 == jsu_pkg::P2_CODE) begin
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < enc.cnt) begin
					burst.ent[n].out_byte = enc.b[k];
					burst.ent[n].has_byte = 1'b1;
					n = n + 3'd1;
				end
			end
		end

		if (dec.mk != jsu_pkg::MK_NONE) begin
			burst.ent[n].done_res   = (dec.mk == jsu_pkg::MK_DONE);
			burst.ent[n].error_code = dec.err;
			n = n + 3'd1;
		end

		if (n != 3'd0) begin
			burst.ent[n - 3'd1].last = 1'b1;
		end
		burst.cnt  = n;
		burst.ends = dec.ended;
	end

endmodule

`default_nettype wire

// File: rtl/jsu_burst.sv
// Result buffer: holds one byte's burst and shifts it out one item per cycle while dec_stall is low.
// Uses jsu_pkg; the head entry drives the output channel directly.
`timescale 1ns / 1ps
`default_nettype none

module jsu_burst (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     load,
	input  wire jsu_pkg::burst_t    burst,
	output logic                    free,
	output logic                    dec_valid,
	input  wire                     dec_stall,
	output jsu_pkg::item_out_t      dec_item
);

	jsu_pkg::item_out_t [jsu_pkg::BURST_MAX-1:0] ent_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign dec_valid = (cnt_q != 3'd0);
	assign dec_item  = ent_q[0];
	assign pop       = dec_valid & ~dec_stall;
	assign free      = (cnt_q == 3'd0) | ((cnt_q == 3'd1) & pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= burst.ent;
		end else if (pop) begin
			for (int i = 0; i < jsu_pkg::BURST_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper: input register, state, decoder, result buffer.
// Depends on jsu_pkg, jsu_decode and jsu_burst.
//
// channel | valid     | stall     | payload                      | dir
// raw     | raw_valid | raw_stall | raw_item (in_byte, last_in)  | in
// dec     | dec_valid | dec_stall | dec_item (out_byte .. last) | out
//
// One raw byte per cycle when each byte yields at most one result item and dec is not stalled.
// A byte yielding N items (N up to 7) holds the next byte in the input register
// while the result buffer shifts them out, one item per cycle unless dec is stalled.
// A raw byte passes the input register and then the result buffer before its first result item.
// arst_n clears the escape state and both valid flags; the next byte is an opening delimiter.
// A stall on dec backs up into raw_stall once the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     raw_valid,
	output logic                    raw_stall,
	input  wire jsu_pkg::item_in_t  raw_item,
	output logic                    dec_valid,
	input  wire                     dec_stall,
	output jsu_pkg::item_out_t      dec_item
);

	jsu_pkg::item_in_t raw_s1;
	logic              vld_s1;
	jsu_pkg::state_t   st_q;
	jsu_pkg::state_t   st_nx;
	jsu_pkg::burst_t   burst;
	logic              free;
	logic              consume;
	logic              load;
	logic              accept;

	assign consume   = vld_s1 & ((burst.cnt == 3'd0) | free);
	assign load      = consume & (burst.cnt != 3'd0);
	assign raw_stall = vld_s1 & ~consume;
	assign accept    = raw_valid & ~raw_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q   <= jsu_pkg::STATE_RESET;
		end else begin
			vld_s1 <= accept | (vld_s1 & ~consume);
			if (consume) begin
				st_q <= st_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= raw_item;
		end
	end

	jsu_decode u_decode (
		.st    (st_q),
		.item  (raw_s1),
		.nx    (st_nx),
		.burst (burst)
	);

	jsu_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.burst     (burst),
		.free      (free),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_valid && (dec_item.done_res || dec_item.error_code != jsu_pkg::ERR_NONE))
		|-> (dec_item.last && !dec_item.has_byte))
		else $error("marker item not last or carries a byte");

	a_load_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!dec_valid || (dec_item.last && !dec_stall)))
		else $error("burst loaded over undelivered items");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && burst.ends)
		|=> (st_q.mode == jsu_pkg::MODE_START && !st_q.high_waiting))
		else $error("state not cleared after done or error");

endmodule

`default_nettype wire

// File: tb/sv/tb_json_string_unescape_utf8_top.sv
// Testbench for json_string_unescape_utf8_top: directed and random JSON string text in,
// decoded UTF-8 result items checked in order against a built-in unescape predictor.
// Depends on jsu_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;

	import jsu_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_TAIL   = 8;
	localparam int RANDOM_ITEMS = 100;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_X  = 8'h78;
	localparam logic [7:0] CH_Q  = 8'h71;

	localparam logic [7:0] ASC_LF  = 8'h0A;
	localparam logic [7:0] ASC_CR  = 8'h0D;
	localparam logic [7:0] ASC_TAB = 8'h09;
	localparam logic [7:0] ASC_BS  = 8'h08;
	localparam logic [7:0] ASC_FF  = 8'h0C;

	localparam logic [7:0][7:0] ESC_SET = {CH_QUOTE, CH_BSL, CH_SLASH, CH_N,
		CH_R, CH_T, CH_B, CH_F};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      raw_valid = 1'b0;
	logic      raw_stall;
	item_in_t  raw_item  = '0;
	logic      dec_valid;
	logic      dec_stall = 1'b0;
	item_out_t dec_item;

	json_string_unescape_utf8_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_item  (raw_item),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	mode_t       st_mode      = MODE_START;
	logic [2:0]  st_hex_cnt   = '0;
	logic [15:0] st_hex_val   = '0;
	logic        st_hex_bad   = 1'b0;
	logic [15:0] st_high      = '0;
	logic        st_high_wait = 1'b0;

	item_out_t  step_q[$];
	item_out_t  utf8_expect_q[$];
	logic [7:0] text_q[$];

	bit idle_en  = 1'b0;
	bit stall_en = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int stall_left = 0;

	int fail_cnt = 0;
	int cycle_cnt = 0;
	int items_sent = 0;
	int strings_sent = 0;
	int results_seen = 0;
	int done_seen = 0;
	int errors_seen = 0;
	int pairs_cnt = 0;
	int max_burst = 0;
	int in_stall_cycles = 0;

	function automatic void clear_run();
		st_mode      = MODE_START;
		st_hex_cnt   = '0;
		st_hex_val   = '0;
		st_hex_bad   = 1'b0;
		st_high      = '0;
		st_high_wait = 1'b0;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		item_out_t r;
		r = '0;
		r.out_byte = b;
		r.has_byte = 1'b1;
		step_q.push_back(r);
	endfunction

	function automatic void put_mark(input logic done, input err_t err);
		item_out_t r;
		r = '0;
		r.done_res   = done;
		r.error_code = err;
		step_q.push_back(r);
	endfunction

	function automatic void put_code(input logic [20:0] c);
		if (c < 21'h80) begin
			put_byte(c[7:0]);
		end else if (c < 21'h800) begin
			put_byte({3'b110, c[10:6]});
			put_byte({2'b10, c[5:0]});
		end else if (c < 21'h10000) begin
			put_byte({4'b1110, c[15:12]});
			put_byte({2'b10, c[11:6]});
			put_byte({2'b10, c[5:0]});
		end else begin
			put_byte({5'b11110, c[20:18]});
			put_byte({2'b10, c[17:12]});
			put_byte({2'b10, c[11:6]});
			put_byte({2'b10, c[5:0]});
		end
	endfunction

	function automatic void flush_high();
		if (st_high_wait) begin
			put_code({5'd0, st_high});
			st_high_wait = 1'b0;
			st_high      = '0;
		end
	endfunction

	// {ok, value}
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_0 + 8'd9) begin
			return {1'b1, 4'(c - CH_0)};
		end
		if (c >= CH_LA && c <= CH_LA + 8'd5) begin
			return {1'b1, 4'(c - CH_LA + 8'd10)};
		end
		if (c >= CH_UA && c <= CH_UA + 8'd5) begin
			return {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return 5'd0;
	endfunction

	function automatic void open_hex();
		st_mode    = MODE_HEX;
		st_hex_cnt = '0;
		st_hex_val = '0;
		st_hex_bad = 1'b0;
	endfunction

	function automatic void unescape_byte(input item_in_t it);
		logic [7:0]  b;
		logic        ended;
		logic [4:0]  nib;
		logic [20:0] hi_off;
		logic [20:0] lo_off;
		err_t        err;
		item_out_t   r;
		b = it.in_byte;
		ended = 1'b0;
		step_q.delete();
		case (st_mode)
			MODE_START: begin
				st_mode = MODE_TEXT;
			end
			MODE_TEXT: begin
				if (st_high_wait && b == CH_BSL) begin
					st_mode = MODE_ESC;
				end else begin
					flush_high();
					if (b == CH_QUOTE) begin
						put_mark(1'b1, ERR_NONE);
						ended = 1'b1;
					end else if (b == CH_BSL) begin
						st_mode = MODE_ESC;
					end else if (b < CH_CTRL_END) begin
						put_mark(1'b0, ERR_CTRL);
						ended = 1'b1;
					end else begin
						put_byte(b);
					end
				end
			end
			MODE_ESC: begin
				if (st_high_wait && b == CH_U) begin
					open_hex();
				end else begin
					flush_high();
					st_mode = MODE_TEXT;
					case (b)
						CH_QUOTE, CH_BSL, CH_SLASH: put_byte(b);
						CH_N: put_byte(ASC_LF);
						CH_R: put_byte(ASC_CR);
						CH_T: put_byte(ASC_TAB);
						CH_B: put_byte(ASC_BS);
						CH_F: put_byte(ASC_FF);
						CH_U: open_hex();
						default: begin
							put_mark(1'b0, ERR_BAD_ESC);
							ended = 1'b1;
						end
					endcase
				end
			end
			default: begin
				nib = nibble_of(b);
				if (!nib[4]) begin
					st_hex_bad = 1'b1;
				end
				st_hex_val = {st_hex_val[11:0], nib[3:0]};
				st_hex_cnt = st_hex_cnt + 3'd1;
				if (st_hex_cnt >= 3'd4) begin
					if (st_hex_bad) begin
						flush_high();
						put_mark(1'b0, ERR_BAD_HEX);
						ended = 1'b1;
					end else if (st_high_wait && st_hex_val >= LO_LO && st_hex_val <= LO_HI) begin
						hi_off = {5'd0, st_high - HI_LO};
						lo_off = {5'd0, st_hex_val - LO_LO};
						st_high_wait = 1'b0;
						st_high      = '0;
						st_mode      = MODE_TEXT;
						pairs_cnt++;
						put_code(SUPP_BASE + (hi_off << 10) + lo_off);
					end else begin
						flush_high();
						st_mode = MODE_TEXT;
						if (st_hex_val >= HI_LO && st_hex_val <= HI_HI) begin
							st_high      = st_hex_val;
							st_high_wait = 1'b1;
						end else begin
							put_code({5'd0, st_hex_val});
						end
					end
				end
			end
		endcase
		if (!ended && it.last_in) begin
			if (st_mode == MODE_ESC) begin
				err = ERR_OPEN_ESC;
			end else if (st_mode == MODE_HEX) begin
				err = ERR_SHORT_HEX;
			end else begin
				err = ERR_UNCLOSED;
			end
			flush_high();
			put_mark(1'b0, err);
			ended = 1'b1;
		end
		if (ended) begin
			clear_run();
		end
		if (step_q.size() > max_burst) begin
			max_burst = step_q.size();
		end
		for (int i = 0; i < step_q.size(); i++) begin
			r = step_q[i];
			r.last = (i == step_q.size() - 1);
			utf8_expect_q.push_back(r);
		end
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int pick_gap();
		int k;
		if (!idle_en) begin
			return 0;
		end
		k = $urandom_range(0, 99);
		if (k < 60) begin
			return 0;
		end
		if (k < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	task automatic send_item(input logic [7:0] b, input logic lst);
		int       gap;
		item_in_t it;
		gap = pick_gap();
		if (gap > 0) begin
			raw_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.in_byte = b;
		it.last_in = lst;
		raw_item  <= it;
		raw_valid <= 1'b1;
		@(posedge clk);
		while (raw_stall) begin
			in_stall_cycles++;
			@(posedge clk);
		end
		unescape_byte(it);
		items_sent++;
	endtask

	task automatic send_text(input logic lst);
		for (int i = 0; i < text_q.size(); i++) begin
			send_item(text_q[i], lst && (i == text_q.size() - 1));
		end
		text_q.delete();
		strings_sent++;
	endtask

	task automatic drain_results();
		raw_valid <= 1'b0;
		while (utf8_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return CH_0 + 8'(n);
		end
		return (($urandom_range(0, 1) != 0) ? CH_UA : CH_LA) + 8'(n - 4'd10);
	endfunction

	function automatic void add_esc(input logic [7:0] c);
		text_q.push_back(CH_BSL);
		text_q.push_back(c);
	endfunction

	function automatic void add_u(input logic [15:0] v);
		add_esc(CH_U);
		for (int i = 3; i >= 0; i--) begin
			text_q.push_back(hex_char(v[i*4 +: 4]));
		end
	endfunction

	function automatic logic esc_known(input logic [7:0] c);
		case (c)
			CH_QUOTE, CH_BSL, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F, CH_U: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_random_piece();
		int         k;
		logic [7:0] c;
		k = $urandom_range(0, 99);
		if (k < 30) begin
			c = 8'($urandom_range(8'h20, 8'h7E));
			if (c == CH_QUOTE || c == CH_BSL) begin
				c = CH_LA;
			end
			text_q.push_back(c);
		end else if (k < 40) begin
			text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
		end else if (k < 55) begin
			add_esc(ESC_SET[$urandom_range(0, 7)]);
		end else if (k < 62) begin
			add_u(16'($urandom_range(0, 16'h7F)));
		end else if (k < 69) begin
			add_u(16'($urandom_range(16'h80, 16'h7FF)));
		end else if (k < 78) begin
			add_u(($urandom_range(0, 1) != 0) ? 16'($urandom_range(16'h800, 16'hD7FF))
				: 16'($urandom_range(16'hE000, 16'hFFFF)));
		end else if (k < 90) begin
			add_u(16'($urandom_range(HI_LO, HI_HI)));
			add_u(16'($urandom_range(LO_LO, LO_HI)));
		end else if (k < 96) begin
			add_u(16'($urandom_range(HI_LO, HI_HI)));
		end else begin
			add_u(16'($urandom_range(LO_LO, LO_HI)));
		end
	endfunction

	// tail that ends the run with an error on its last byte
	function automatic void add_error_tail();
		logic [7:0] c;
		int         pos;
		case ($urandom_range(0, 2))
			0: begin
				do c = 8'($urandom_range(0, 255)); while (esc_known(c));
				add_esc(c);
			end
			1: begin
				text_q.push_back(8'($urandom_range(0, 8'h1F)));
			end
			default: begin
				add_esc(CH_U);
				pos = $urandom_range(0, 3);
				for (int i = 0; i < 4; i++) begin
					if (i == pos) begin
						do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 5'h10);
						text_q.push_back(c);
					end else begin
						text_q.push_back(hex_char(4'($urandom_range(0, 15))));
					end
				end
			end
		endcase
	endfunction

	task automatic send_random_string();
		int   n;
		int   k;
		int   cut;
		logic lst;
		text_q.delete();
		text_q.push_back(8'($urandom_range(0, 255)));
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
		repeat (n) add_random_piece();
		lst = 1'b0;
		k = $urandom_range(0, 99);
		if (k < 75) begin
			text_q.push_back(CH_QUOTE);
			lst = ($urandom_range(0, 3) == 0);
		end else if (k < 88) begin
			add_error_tail();
		end else begin
			cut = $urandom_range(1, text_q.size());
			while (text_q.size() > cut) void'(text_q.pop_back());
			lst = 1'b1;
		end
		send_text(lst);
	endtask

	// ---------------- receiver and checker ----------------

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			dec_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			dec_stall <= 1'b1;
		end else if (stall_en && $urandom_range(0, 99) < 25) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 25)
				: $urandom_range(0, 2);
			dec_stall <= 1'b1;
		end else begin
			dec_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin
		item_out_t exp_item;
		if (arst_n && dec_valid && !dec_stall) begin
			if (utf8_expect_q.size() == 0) begin
				$error("result item with none expected: 0x%0h", dec_item);
				fail_cnt++;
			end else begin
				exp_item = utf8_expect_q.pop_front();
				check_field("out_byte", exp_item.out_byte, dec_item.out_byte);
				check_field("has_byte", 8'(exp_item.has_byte), 8'(dec_item.has_byte));
				check_field("done_res", 8'(exp_item.done_res), 8'(dec_item.done_res));
				check_field("error_code", 8'(exp_item.error_code), 8'(dec_item.error_code));
				check_field("last", 8'(exp_item.last), 8'(dec_item.last));
			end
			results_seen++;
			if (dec_item.done_res === 1'b1) begin
				done_seen++;
			end
			if (dec_item.error_code != ERR_NONE) begin
				errors_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				utf8_expect_q.size());
			$display("FAIL json_string_unescape_utf8_top");
			$finish;
		end
	end

	// ---------------- tests ----------------

	task automatic test_plain_bytes();
		text_q = '{8'hFF, 8'h20, 8'h7E, 8'h80, 8'hFF, CH_QUOTE};
		send_text(1'b0);
		text_q = '{8'h00, CH_UA, CH_QUOTE};
		send_text(1'b1);
		drain_results();
	endtask

	task automatic test_simple_escapes();
		text_q.push_back(CH_QUOTE);
		for (int i = 0; i < 8; i++) begin
			add_esc(ESC_SET[i]);
		end
		text_q.push_back(CH_QUOTE);
		send_text(1'b0);
		drain_results();
	endtask

	task automatic test_unicode_escapes();
		text_q.push_back(CH_QUOTE);
		add_u(16'h0000);
		add_u(16'h007F);
		add_u(16'h0080);
		add_u(16'h07FF);
		add_u(16'h0800);
		add_u(16'hFFFF);
		add_u(HI_LO);
		add_u(LO_LO);
		add_u(HI_HI);
		add_u(LO_HI);
		add_u(16'hD83D);
		text_q.push_back(CH_LA);
		add_u(LO_LO);
		add_u(HI_LO);
		add_esc(CH_N);
		add_u(HI_LO);
		add_u(16'hD801);
		add_u(16'hDC37);
		add_u(HI_HI);
		add_u(16'h0041);
		add_u(HI_LO);
		text_q.push_back(CH_QUOTE);
		send_text(1'b0);
		drain_results();
	endtask

	task automatic test_run_errors();
		// end of text on the opening delimiter
		text_q = '{CH_QUOTE};
		send_text(1'b1);
		text_q = '{CH_QUOTE, CH_UA};
		send_text(1'b1);
		// held high surrogate flushed before the unclosed error
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		send_text(1'b1);
		text_q = '{CH_QUOTE, CH_BSL};
		send_text(1'b1);
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		text_q.push_back(CH_BSL);
		send_text(1'b1);
		text_q = '{CH_QUOTE, CH_BSL, CH_U, CH_0 + 8'd1, CH_0 + 8'd2};
		send_text(1'b1);
		// bad digit, but text ends before four digits
		text_q = '{CH_QUOTE, CH_BSL, CH_U, CH_X};
		send_text(1'b1);
		text_q = '{CH_QUOTE, CH_BSL, CH_U, CH_0 + 8'd1, CH_X, CH_0 + 8'd2, CH_0 + 8'd3};
		send_text(1'b0);
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		text_q = {text_q, CH_BSL, CH_U, CH_X, CH_X, CH_X, CH_X};
		send_text(1'b0);
		text_q = '{CH_QUOTE, CH_BSL, CH_Q};
		send_text(1'b0);
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		add_esc(CH_Q);
		send_text(1'b0);
		text_q = '{CH_QUOTE, 8'h1F};
		send_text(1'b0);
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		text_q.push_back(8'h00);
		send_text(1'b0);
		// flushed high, a 3-byte code and the unclosed error from one byte
		text_q = '{CH_QUOTE};
		add_u(HI_LO);
		add_u(16'h0800);
		send_text(1'b1);
		text_q = '{CH_QUOTE, CH_QUOTE};
		send_text(1'b1);
		drain_results();
	endtask

	task automatic test_backpressure();
		idle_en  = 1'b0;
		stall_en = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (6) send_random_string();
		drain_results();
	endtask

	task automatic test_random_text();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			idle_en  = ($urandom_range(0, 4) != 0);
			stall_en = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 99) < 85) begin
				send_random_string();
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
				end
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_en  = 1'b1;
		stall_en = 1'b1;
		test_plain_bytes();
		test_simple_escapes();
		test_unicode_escapes();
		test_run_errors();
		test_backpressure();
		test_random_text();
		if (utf8_expect_q.size() != 0) begin
			$error("%0d expected result items never arrived", utf8_expect_q.size());
			fail_cnt++;
		end
		$display("Sent %0d items in %0d strings, input stalled %0d cycles; checked %0d results",
			items_sent, strings_sent, in_stall_cycles, results_seen);
		$display("Seen %0d done and %0d error markers, %0d surrogate pairs, burst up to %0d",
			done_seen, errors_seen, pairs_cnt, max_burst);
		if (fail_cnt == 0) begin
			$display("PASS json_string_unescape_utf8_top");
		end else begin
			$display("FAIL json_string_unescape_utf8_top");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_burst.sv
rtl/json_string_unescape_utf8_top.sv
tb/sv/tb_json_string_unescape_utf8_top.sv
